@@ rtl/baro_pkg.sv @@
// Shared types, register indexes, constants and helpers for the barometric compensation block.
package baro_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_TEMP       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LOW  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_MID  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_LAST = 2'd3;

	localparam logic [31:0] OFFSET_64000 = 32'd64000;
	localparam logic [31:0] ONE_SHL20    = 32'd1048576;
	localparam logic [31:0] SCALE_3125   = 32'd3125;
	localparam logic [31:0] HALF_SCALE   = 32'd32768;
	localparam logic [31:0] ROUND_128    = 32'd128;

	typedef struct packed {
		logic [47:0] temp;
		logic [63:0] press_low;
		logic [63:0] press_mid;
		logic [15:0] press_last;
	} coeffs_t;

	typedef struct packed {
		logic        dz;
		logic        kind;
		logic [31:0] press;
		logic [15:0] temp;
	} result_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_T0, ST_T1, ST_T2, ST_T3, ST_T4,
		ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7,
		ST_P8, ST_P9, ST_P10, ST_DIV, ST_P11, ST_P12, ST_P13, ST_P14, ST_P15,
		ST_DONE
	} state_t;

	function automatic logic [31:0] asr(input logic [31:0] x, input logic [4:0] n);
		logic signed [31:0] xs;
		xs = x;
		return xs >>> n;
	endfunction

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

@@ rtl/baro_mul.sv @@
// Shared 32 by 32 multiplier keeping the low 32 bits, with a registered product.
module baro_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

@@ rtl/baro_div.sv @@
// Unsigned 32-bit restoring divider producing one quotient bit per cycle.
module baro_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done_q,
	output logic [31:0] quo_q
);

	localparam int unsigned STEPS = 32;
	localparam int unsigned CNT_W = $clog2(STEPS);
	localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [31:0]      rem_q;
	logic [31:0]      dsr_q;
	logic [32:0]      rem_sh;
	logic [32:0]      diff;
	logic             ge;

	assign rem_sh = {rem_q, quo_q[31]};
	assign diff   = rem_sh - {1'b0, dsr_q};
	assign ge     = ~diff[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : rem_sh[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

endmodule

@@ rtl/baro_core.sv @@
// Sequencer and datapath that run the compensation formulas on the shared multiplier and divider.
module baro_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [19:0]         raw_sample,
	input  baro_pkg::coeffs_t   coeffs,
	output logic                res_valid,
	input  logic                res_ready,
	output baro_pkg::result_t   res
);

	import baro_pkg::*;

	state_t      state_q, state_d;
	logic        kind_q;
	logic [19:0] adc_q;
	logic [31:0] fine_q;
	logic [31:0] v1_q, v2_q, sq_q, t_q, x_q, p_q;
	logic        big_q;
	logic [15:0] res_temp_q;
	logic [31:0] res_press_q;
	logic        res_dz_q;

	logic [31:0] mul_a, mul_b, prod_q;
	logic        div_start, div_done;
	logic [31:0] div_dividend, div_quo;

	logic [31:0] adc32;
	logic [31:0] t1, t2, t3;
	logic [31:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
	logic [31:0] temp_calc, p6_sum;

	assign adc32 = {12'd0, adc_q};
	assign t1 = {16'd0, coeffs.temp[15:0]};
	assign t2 = sx16(coeffs.temp[31:16]);
	assign t3 = sx16(coeffs.temp[47:32]);
	assign p1 = {16'd0, coeffs.press_low[15:0]};
	assign p2 = sx16(coeffs.press_low[31:16]);
	assign p3 = sx16(coeffs.press_low[47:32]);
	assign p4 = sx16(coeffs.press_low[63:48]);
	assign p5 = sx16(coeffs.press_mid[15:0]);
	assign p6 = sx16(coeffs.press_mid[31:16]);
	assign p7 = sx16(coeffs.press_mid[47:32]);
	assign p8 = sx16(coeffs.press_mid[63:48]);
	assign p9 = sx16(coeffs.press_last);

	assign temp_calc = asr((fine_q << 2) + fine_q + ROUND_128, 5'd8);
	assign p6_sum    = t_q + asr(prod_q, 5'd1);
	assign div_dividend = prod_q[31] ? prod_q : (prod_q << 1);

	baro_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	baro_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (x_q),
		.done_q   (div_done),
		.quo_q    (div_quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = req_type ? ST_P0 : ST_T0;
				end
			end
			ST_T0:  state_d = ST_T1;
			ST_T1:  state_d = ST_T2;
			ST_T2:  state_d = ST_T3;
			ST_T3:  state_d = ST_T4;
			ST_T4:  state_d = ST_DONE;
			ST_P0:  state_d = ST_P1;
			ST_P1:  state_d = ST_P2;
			ST_P2:  state_d = ST_P3;
			ST_P3:  state_d = ST_P4;
			ST_P4:  state_d = ST_P5;
			ST_P5:  state_d = ST_P6;
			ST_P6:  state_d = ST_P7;
			ST_P7:  state_d = ST_P8;
			ST_P8:  state_d = ST_P9;
			ST_P9:  state_d = (x_q == '0) ? ST_DONE : ST_P10;
			ST_P10: state_d = ST_DIV;
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_P11;
				end
			end
			ST_P11: state_d = ST_P12;
			ST_P12: state_d = ST_P13;
			ST_P13: state_d = ST_P14;
			ST_P14: state_d = ST_P15;
			ST_P15: state_d = ST_DONE;
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_T0: begin
				mul_a = (adc32 >> 3) - (t1 << 1);
				mul_b = t2;
			end
			ST_T1: begin
				mul_a = t_q;
				mul_b = t_q;
			end
			ST_T2: begin
				mul_a = asr(prod_q, 5'd12);
				mul_b = t3;
			end
			ST_P1: begin
				mul_a = asr(v1_q, 5'd2);
				mul_b = asr(v1_q, 5'd2);
			end
			ST_P2: begin
				mul_a = v1_q;
				mul_b = p5;
			end
			ST_P3: begin
				mul_a = asr(sq_q, 5'd11);
				mul_b = p6;
			end
			ST_P4: begin
				mul_a = p3;
				mul_b = asr(sq_q, 5'd13);
			end
			ST_P5: begin
				mul_a = p2;
				mul_b = v1_q;
			end
			ST_P7: begin
				mul_a = x_q;
				mul_b = p1;
			end
			ST_P9: begin
				mul_a = t_q;
				mul_b = SCALE_3125;
			end
			ST_P10: div_start = 1'b1;
			ST_P11: begin
				mul_a = p_q >> 3;
				mul_b = p_q >> 3;
			end
			ST_P12: begin
				mul_a = p9;
				mul_b = prod_q >> 13;
			end
			ST_P13: begin
				mul_a = p_q >> 2;
				mul_b = p8;
			end
			ST_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fine_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_T3) begin
				fine_q <= v1_q + asr(prod_q, 5'd14);
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					kind_q <= req_type;
					adc_q  <= raw_sample;
				end
			end
			ST_T0: t_q <= (adc32 >> 4) - t1;
			ST_T1: v1_q <= asr(prod_q, 5'd11);
			ST_T4: begin
				res_temp_q  <= temp_calc[15:0];
				res_press_q <= '0;
				res_dz_q    <= 1'b0;
			end
			ST_P0: v1_q <= asr(fine_q, 5'd1) - OFFSET_64000;
			ST_P2: sq_q <= prod_q;
			ST_P3: t_q <= prod_q << 1;
			ST_P4: v2_q <= asr(prod_q + t_q, 5'd2) + (p4 << 16);
			ST_P5: t_q <= asr(prod_q, 5'd3);
			ST_P6: x_q <= HALF_SCALE + asr(p6_sum, 5'd18);
			ST_P8: begin
				x_q <= asr(prod_q, 5'd15);
				t_q <= (ONE_SHL20 - adc32) - asr(v2_q, 5'd12);
			end
			ST_P9: begin
				if (x_q == '0) begin
					res_temp_q  <= '0;
					res_press_q <= '0;
					res_dz_q    <= 1'b1;
				end
			end
			ST_P10: big_q <= prod_q[31];
			ST_DIV: begin
				if (div_done) begin
					p_q <= big_q ? (div_quo << 1) : div_quo;
				end
			end
			ST_P13: t_q <= asr(prod_q, 5'd12);
			ST_P14: t_q <= t_q + asr(prod_q, 5'd13) + p7;
			ST_P15: begin
				res_temp_q  <= '0;
				res_press_q <= p_q + asr(t_q, 5'd4);
				res_dz_q    <= 1'b0;
			end
			default: ;
		endcase
	end

	assign res.dz    = res_dz_q;
	assign res.kind  = kind_q;
	assign res.press = res_press_q;
	assign res.temp  = res_temp_q;

endmodule

@@ rtl/baro_temp_pressure_compensation.sv @@
// Top level: calibration registers, stream ports and result register around the compensation core.
//
//  Channel  | Signals                                  | Contents
//  ---------+------------------------------------------+-------------------------------------
//  s_axis   | tvalid, tready, tdata[23:0], tuser[0:0]  | raw sample in, sample kind
//  m_axis   | tvalid, tready, tdata[47:0], tuser[1:0]  | temperature, pressure, kind, flag
//  cfg      | cfg_we, cfg_index[1:0], cfg_data[63:0]   | calibration register writes
//
// A temperature transaction runs through states T0 to T4 on the shared multiplier before
// its result is presented. A pressure transaction runs through states P0 to P15, with the
// bit-serial divider between P10 and P11; a zero divisor ends it after state P9.
// The input is ready only while the sequencer is idle, from the cycle after the result moves
// on; the result register lets it wait for m_axis_tready while the next sample is taken.
// Reset clears the calibration registers and the stored fine temperature.
module baro_temp_pressure_compensation (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [23:0]                   s_axis_tdata,  // raw_sample[19:0], zero pad
	input  logic [0:0]                    s_axis_tuser,  // req_type
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [47:0]                   m_axis_tdata,  // temperature_centi, pressure_pa
	output logic [1:0]                    m_axis_tuser,  // result_kind, divide_zero
	input  logic                          cfg_we,
	input  logic [baro_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [baro_pkg::CFG_DATA_W-1:0] cfg_data
);

	import baro_pkg::*;

	coeffs_t coeffs_q;
	result_t core_res;
	result_t out_q;
	logic    out_valid_q;
	logic    core_valid, core_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeffs_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMP:       coeffs_q.temp       <= cfg_data[47:0];
				REG_PRESS_LOW:  coeffs_q.press_low  <= cfg_data;
				REG_PRESS_MID:  coeffs_q.press_mid  <= cfg_data;
				REG_PRESS_LAST: coeffs_q.press_last <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	baro_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.req_type   (s_axis_tuser[0]),
		.raw_sample (s_axis_tdata[19:0]),
		.coeffs     (coeffs_q),
		.res_valid  (core_valid),
		.res_ready  (core_ready),
		.res        (core_res)
	);

	assign core_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (core_ready) begin
			out_valid_q <= core_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (core_ready && core_valid) begin
			out_q <= core_res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.press, out_q.temp};
	assign m_axis_tuser  = {out_q.dz, out_q.kind};

endmodule
